/* rtl/cde_pkg.sv */
// Package for the circular deque: transaction types, operation and status codes.
package cde_pkg;

   localparam int unsigned DataWidth = 32;

   // Operation codes carried in the request mode field
   localparam logic [1:0] MODE_PUSH_FRONT = 2'd0;
   localparam logic [1:0] MODE_PUSH_REAR  = 2'd1;
   localparam logic [1:0] MODE_POP_FRONT  = 2'd2;
   localparam logic [1:0] MODE_POP_REAR   = 2'd3;

   // Status codes returned with every response
   localparam logic [1:0] STATUS_OK        = 2'd0;
   localparam logic [1:0] STATUS_OVERFLOW  = 2'd1;
   localparam logic [1:0] STATUS_UNDERFLOW = 2'd2;

   typedef struct packed {
      logic [1:0]                  mode;
      logic signed [DataWidth-1:0] value;
   } req_type;

   typedef struct packed {
      logic signed [DataWidth-1:0] data;
      logic [1:0]                  status;
      logic                        is_empty;
      logic                        is_full;
   } rsp_type;

   // Per-cycle command broadcast to every cell of the chain
   typedef struct packed {
      logic shift_right;  // push at the front: every element moves one place back
      logic shift_left;   // pop at the front: every element moves one place forward
      logic push_rear;    // first empty cell takes the new element
      logic pop_rear;     // last occupied cell drops its element
   } cell_ctrl_type;

endpackage

/* rtl/cde_cell.sv */
// One storage cell of the deque chain: an element, its occupied flag and neighbour hand-off.
module cde_cell (
   input  logic                                  clock,
   input  logic                                  reset,
   input  cde_pkg::cell_ctrl_type                ctrl,
   input  logic signed [cde_pkg::DataWidth-1:0]  push_value,
   input  logic signed [cde_pkg::DataWidth-1:0]  front_data,   // neighbour nearer the front
   input  logic                                  front_valid,
   input  logic signed [cde_pkg::DataWidth-1:0]  back_data,    // neighbour nearer the rear
   input  logic                                  back_valid,
   output logic signed [cde_pkg::DataWidth-1:0]  data,
   output logic                                  valid,
   output logic signed [cde_pkg::DataWidth-1:0]  rear_data     // own element if this is the rear
);

   logic signed [cde_pkg::DataWidth-1:0] data_ff, data_in;
   logic                                 valid_ff, valid_in;
   logic                                 is_rear;

   assign is_rear = valid_ff & ~back_valid;

   // Next contents from the broadcast command and the two neighbours
   always_comb begin
      data_in  = data_ff;
      valid_in = valid_ff;
      if (ctrl.shift_right) begin
         data_in  = front_data;
         valid_in = front_valid;
      end else if (ctrl.shift_left) begin
         data_in  = back_data;
         valid_in = back_valid;
      end else if (ctrl.push_rear) begin
         if (front_valid & ~valid_ff) begin
            data_in  = push_value;
            valid_in = 1'b1;
         end
      end else if (ctrl.pop_rear) begin
         if (is_rear) begin
            valid_in = 1'b0;
         end
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         valid_ff <= 1'b0;
      end else begin
         valid_ff <= valid_in;
      end
   end

   // Element store needs no reset
   always_ff @(posedge clock) begin
      data_ff <= data_in;
   end

   assign data      = data_ff;
   assign valid     = valid_ff;
   assign rear_data = is_rear ? data_ff : '0;

endmodule

/* rtl/circular_deque.sv */
// Top level of the double-ended queue built as a chain of shifting cells.
//
// Usage: drive req_payload (mode, value) and raise start while busy is low;
// that edge accepts the transaction. Modes: push front, push rear, pop front,
// pop rear. Exactly one response follows for every transaction: rsp_valid is
// high for one cycle, the cycle after acceptance, with rsp_payload holding the
// popped element (zero unless a pop succeeds), a status (ok, overflow on a push
// into a full deque, underflow on a pop from an empty one) and the empty and
// full flags as they stand after the operation. Failed operations leave the
// contents untouched.
// A new transaction can be taken every cycle: each cell updates from its
// neighbours in the same edge, and the rear element is picked out by an
// AND-OR reduction over the cells' rear outputs.
// Element 0 of the chain is always the front; occupancy is a contiguous run
// of valid flags from the front.
// Reset (synchronous, active high) empties the deque; busy is high for the
// first cycle after reset and low from then on. The receiver cannot stall,
// so responses must be taken in the cycle they are shown.
module circular_deque #(
   parameter int unsigned DEPTH = 16
) (
   input  logic             clock,
   input  logic             reset,
   input  logic             start,
   output logic             busy,
   input  cde_pkg::req_type req_payload,
   output logic             rsp_valid,
   output cde_pkg::rsp_type rsp_payload
);

   localparam int unsigned DW = cde_pkg::DataWidth;

   logic                     busy_ff;
   logic                     accept;
   logic                     is_empty, is_full;
   logic                     is_push, op_ok;
   cde_pkg::cell_ctrl_type   ctrl;

   logic signed [DW-1:0]     cell_data [DEPTH];
   logic                     cell_valid [DEPTH];
   logic signed [DW-1:0]     cell_rear [DEPTH];
   logic signed [DW-1:0]     rear_value;

   logic                     rsp_valid_ff;
   logic signed [DW-1:0]     rsp_data_ff, rsp_data_in;
   logic [1:0]               rsp_status_ff, rsp_status_in;

   assign accept   = start & ~busy_ff;
   assign is_empty = ~cell_valid[0];
   assign is_full  = cell_valid[DEPTH-1];
   assign is_push  = (req_payload.mode == cde_pkg::MODE_PUSH_FRONT) ||
                     (req_payload.mode == cde_pkg::MODE_PUSH_REAR);
   assign op_ok    = is_push ? ~is_full : ~is_empty;

   // Command decode for the cell chain
   always_comb begin
      ctrl = '0;
      if (accept && op_ok) begin
         unique case (req_payload.mode)
            cde_pkg::MODE_PUSH_FRONT: ctrl.shift_right = 1'b1;
            cde_pkg::MODE_PUSH_REAR:  ctrl.push_rear   = 1'b1;
            cde_pkg::MODE_POP_FRONT:  ctrl.shift_left  = 1'b1;
            cde_pkg::MODE_POP_REAR:   ctrl.pop_rear    = 1'b1;
            default:                  ctrl = '0;
         endcase
      end
   end

   // Chain of cells, front at index 0
   for (genvar i = 0; i < DEPTH; i++) begin : g_cell
      logic signed [DW-1:0] front_d, back_d;
      logic                 front_v, back_v;

      if (i == 0) begin : g_head
         assign front_d = req_payload.value;
         assign front_v = 1'b1;
      end else begin : g_mid
         assign front_d = cell_data[i-1];
         assign front_v = cell_valid[i-1];
      end

      if (i == DEPTH-1) begin : g_tail
         assign back_d = '0;
         assign back_v = 1'b0;
      end else begin : g_inner
         assign back_d = cell_data[i+1];
         assign back_v = cell_valid[i+1];
      end

      cde_cell u_cell (
         .clock       (clock),
         .reset       (reset),
         .ctrl        (ctrl),
         .push_value  (req_payload.value),
         .front_data  (front_d),
         .front_valid (front_v),
         .back_data   (back_d),
         .back_valid  (back_v),
         .data        (cell_data[i]),
         .valid       (cell_valid[i]),
         .rear_data   (cell_rear[i])
      );
   end

   // At most one cell is the rear, so an OR reduction selects it
   always_comb begin
      rear_value = '0;
      for (int i = 0; i < DEPTH; i++) begin
         rear_value = rear_value | cell_rear[i];
      end
   end

   // Response data and status
   always_comb begin
      rsp_data_in   = '0;
      rsp_status_in = cde_pkg::STATUS_OK;
      if (!op_ok) begin
         rsp_status_in = is_push ? cde_pkg::STATUS_OVERFLOW : cde_pkg::STATUS_UNDERFLOW;
      end else if (req_payload.mode == cde_pkg::MODE_POP_FRONT) begin
         rsp_data_in = cell_data[0];
      end else if (req_payload.mode == cde_pkg::MODE_POP_REAR) begin
         rsp_data_in = rear_value;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         busy_ff      <= 1'b1;
         rsp_valid_ff <= 1'b0;
      end else begin
         busy_ff      <= 1'b0;
         rsp_valid_ff <= accept;
      end
   end

   always_ff @(posedge clock) begin
      if (accept) begin
         rsp_data_ff   <= rsp_data_in;
         rsp_status_ff <= rsp_status_in;
      end
   end

   // Flags come straight from the cells: in the response cycle they hold the post-step state
   assign busy                 = busy_ff;
   assign rsp_valid            = rsp_valid_ff;
   assign rsp_payload.data     = rsp_data_ff;
   assign rsp_payload.status   = rsp_status_ff;
   assign rsp_payload.is_empty = is_empty;
   assign rsp_payload.is_full  = is_full;

   // Occupancy must stay a contiguous run from the front
   logic occupancy_ok;
   always_comb begin
      occupancy_ok = 1'b1;
      for (int i = 1; i < DEPTH; i++) begin
         if (cell_valid[i] && !cell_valid[i-1]) begin
            occupancy_ok = 1'b0;
         end
      end
   end

   a_occupancy_contiguous: assert property (@(posedge clock) disable iff (reset)
      occupancy_ok)
      else $error("deque occupancy has a gap");

   a_not_empty_and_full: assert property (@(posedge clock) disable iff (reset)
      !(is_empty && is_full))
      else $error("deque flagged empty and full at once");

   a_one_response_per_transaction: assert property (@(posedge clock) disable iff (reset)
      accept |=> rsp_valid)
      else $error("accepted transaction produced no response");

   a_failed_op_zero_data: assert property (@(posedge clock) disable iff (reset)
      (rsp_valid && rsp_payload.status != cde_pkg::STATUS_OK) |-> (rsp_payload.data == '0))
      else $error("failed operation returned non-zero data");

   a_failed_op_keeps_state: assert property (@(posedge clock) disable iff (reset)
      (accept && !op_ok) |=> ($stable(is_empty) && $stable(is_full)))
      else $error("failed operation changed the occupancy");

endmodule
